// ===== sv/grmc_pkg.sv =====
`default_nettype none
package grmc_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;
   localparam int MAP_COLUMNS   = 10;
   localparam int MAP_ROWS      = 6;
   localparam int SINE_DEPTH    = 256;
   localparam int SINE_IDX_W    = $clog2(SINE_DEPTH);

   localparam int WALL_W      = 60;
   localparam int MOVE_W      = 12;
   localparam int TURN_W      = 13;
   localparam int MARCH_W     = 12;
   localparam int MAXD_W      = 17;
   localparam int COL_W       = 10;
   localparam int SPAN_W      = 9;
   localparam int POS_W       = 16;
   localparam int POSY_OUT_W  = 15;
   localparam int ANGLE_W     = 16;
   localparam int TRIG_W      = 16;
   localparam int DIST_W      = 18;
   localparam int MUL_A_W     = DIST_W + 1;
   localparam int PROD_W      = MUL_A_W + TRIG_W;
   localparam int COORD_W     = 20;
   localparam int CELL_W      = $clog2(MAP_COLUMNS * MAP_ROWS);
   localparam int FRAC_BITS   = 12;

   localparam int FOV_ANGLE   = 10923;
   localparam int HALF_FOV    = 5461;
   localparam int QUARTER     = 16384;
   localparam int DIST_SAT    = 131071;

   // column * FOV_ANGLE / SCREEN_WIDTH by reciprocal multiply, exact for 10-bit columns
   localparam int     REL_SHIFT  = 20;
   localparam int     REL_PROD_W = ANGLE_W + REL_SHIFT;
   localparam longint REL_MUL    = (longint'(FOV_ANGLE) * (longint'(1) << REL_SHIFT)
                                    + SCREEN_WIDTH - 1) / SCREEN_WIDTH;

   localparam int DIV_N_W     = 25;
   localparam int DIV_D_W     = 18;
   localparam int DIV_CNT_W   = $clog2(DIV_N_W + 1);

   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 96;

   localparam logic [WALL_W-1:0]  WALL_MAP_RESET     = 60'd1152360274319722495;
   localparam logic [MOVE_W-1:0]  MOVE_STEP_RESET    = 12'd410;
   localparam logic [TURN_W-1:0]  TURN_STEP_RESET    = 13'd834;
   localparam logic [MARCH_W-1:0] MARCH_STEP_RESET   = 12'd205;
   localparam logic [MAXD_W-1:0]  MAX_DISTANCE_RESET = 17'd81920;
   localparam logic [POS_W-1:0]   POS_RESET          = 16'd12288;

   typedef enum logic [2:0] {
      REG_WALL_MAP     = 3'd0,
      REG_MOVE_STEP    = 3'd1,
      REG_TURN_STEP    = 3'd2,
      REG_MARCH_STEP   = 3'd3,
      REG_MAX_DISTANCE = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      MUL_MARCH = 2'd0,
      MUL_WALK  = 2'd1,
      MUL_CORR  = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic [WALL_W-1:0]  wall_map;
      logic [MOVE_W-1:0]  move_step;
      logic [TURN_W-1:0]  turn_step;
      logic [MARCH_W-1:0] march_step;
      logic [MAXD_W-1:0]  max_distance;
   } cfg_type;

   typedef struct packed {
      logic        load_item;
      logic        div_start;
      logic        angle_load;
      logic        dist_step;
      mul_sel_type mul_sel;
      logic        mul_load;
      logic        walk_dir_back;
      logic        walk_x_upd;
      logic        walk_y_upd;
      logic        turn;
      logic        out_load;
      logic        out_cast;
   } dp_cmd_type;

   typedef struct packed {
      logic in_op;
      logic in_fwd;
      logic in_back;
      logic key_back;
      logic div_done;
      logic hit;
      logic dist_lt_max;
      logic max_zero;
   } dp_status_type;

   typedef logic signed [TRIG_W-1:0] sine_table_type [SINE_DEPTH];

   function automatic logic signed [TRIG_W-1:0] sine_entry(input int idx);
      int q;
      int quad;
      int frac;
      int x;
      int x2;
      int t;
      q    = idx * (65536 / SINE_DEPTH);
      quad = (q >> 14) & 3;
      frac = q & 16383;
      x    = ((quad & 1) != 0) ? (QUARTER - frac) : frac;
      x2   = (x * x) >> 14;
      t    = (1232 * x2) >> 14;
      t    = 10584 - t;
      t    = (t * x2) >> 14;
      t    = 25736 - t;
      t    = (t * x) >> 14;
      if ((quad & 2) != 0) begin
         t = -t;
      end
      return TRIG_W'(t);
   endfunction

   function automatic sine_table_type build_sine();
      sine_table_type tab;
      for (int i = 0; i < SINE_DEPTH; i++) begin
         tab[i] = sine_entry(i);
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine();

   function automatic logic signed [TRIG_W-1:0] sine_lookup(input logic [ANGLE_W-1:0] a);
      return SINE_TABLE[a[ANGLE_W-1 -: SINE_IDX_W]];
   endfunction

   function automatic logic signed [COORD_W-1:0] round_q14(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] sh;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      sh  = (mag + PROD_W'(8192)) >> 14;
      return p[PROD_W-1] ? $signed(-sh[COORD_W-1:0]) : $signed(sh[COORD_W-1:0]);
   endfunction

endpackage
`default_nettype wire

// ===== sv/grid_ray_march_column_caster.sv =====
// Grid ray-march column caster.
// Input stream (req_): one beat is either a move (tuser = 0) that applies the
// held keys to the player, or a cast (tuser = 1) that marches the ray of one
// screen column over the wall grid. Every input beat yields exactly one output
// beat (rsp_) carrying the wall row span, the hit distance and the player
// position and heading after the item.
// A move walks if forward or back is held (forward, then back if both are),
// each walk a multiply, an x update and a y update, then turns. A cast loads
// the ray angle, marches up to ceil(max_distance / march_step) steps, each a
// multiply state and a grid-check state, then divides on a radix-2 divider.
// One item is processed at a time; req_tready is high while idle.
// A finished result sits in the output register; the block accepts the next
// beat while it waits, and holds its next result until rsp_tready drains it.
// Reset (synchronous) puts the player at (3.0, 3.0) heading 0, loads the
// register defaults and empties the output. The user writes registers through
// the csr_ port only while no item is in flight; the block does not enforce it.
`default_nettype none
module grid_ray_march_column_caster
   import grmc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [0] key_forward, [1] key_back, [2] key_turn_left, [3] key_turn_right,
   // [13:4] column
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [9:0] column_out, [18:10] span_start, [27:19] span_end,
   // [44:28] ray_distance, [60:45] player_x, [75:61] player_y,
   // [91:76] player_heading
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_wr;
   reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wall_map     <= WALL_MAP_RESET;
         cfg_ff.move_step    <= MOVE_STEP_RESET;
         cfg_ff.turn_step    <= TURN_STEP_RESET;
         cfg_ff.march_step   <= MARCH_STEP_RESET;
         cfg_ff.max_distance <= MAX_DISTANCE_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_WALL_MAP:     cfg_ff.wall_map     <= csr_pwdata[WALL_W-1:0];
            REG_MOVE_STEP:    cfg_ff.move_step    <= csr_pwdata[MOVE_W-1:0];
            REG_TURN_STEP:    cfg_ff.turn_step    <= csr_pwdata[TURN_W-1:0];
            REG_MARCH_STEP:   cfg_ff.march_step   <= csr_pwdata[MARCH_W-1:0];
            REG_MAX_DISTANCE: cfg_ff.max_distance <= csr_pwdata[MAXD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_WALL_MAP:     csr_prdata = CSR_DATA_W'(cfg_ff.wall_map);
         REG_MOVE_STEP:    csr_prdata = CSR_DATA_W'(cfg_ff.move_step);
         REG_TURN_STEP:    csr_prdata = CSR_DATA_W'(cfg_ff.turn_step);
         REG_MARCH_STEP:   csr_prdata = CSR_DATA_W'(cfg_ff.march_step);
         REG_MAX_DISTANCE: csr_prdata = CSR_DATA_W'(cfg_ff.max_distance);
         default:          csr_prdata = '0;
      endcase
   end

   grmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   grmc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is in flight");

   a_span_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:10] <= rsp_tdata[27:19]))
      else $error("span start past span end");

   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== sv/grmc_div.sv =====
`default_nettype none
module grmc_div
   import grmc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] dividend,
   input  wire logic [DIV_D_W-1:0] divisor,
   output logic                    done,
   output logic [DIV_N_W-1:0]      quotient
);

   logic [DIV_D_W:0]     rem_ff, rem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_D_W:0]     rem_shift;
   logic                 fits;

   always_comb begin
      rem_shift = {rem_ff[DIV_D_W-1:0], quo_ff[DIV_N_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_shift - {1'b0, dvs_ff}) : rem_shift;
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== sv/grmc_dp.sv =====
`default_nettype none
module grmc_dp
   import grmc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic [POS_W-1:0]        pos_x_ff, pos_x_in;
   logic [POS_W-1:0]        pos_y_ff, pos_y_in;
   logic [ANGLE_W-1:0]      heading_ff, heading_in;
   logic [COL_W-1:0]        col_ff;
   logic                    left_ff, right_ff, back_ff;
   logic [ANGLE_W-1:0]      ray_ff, ray_in;
   logic [ANGLE_W-1:0]      diff_ff, diff_in;
   logic [DIST_W-1:0]       dist_ff, dist_in;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff;
   logic [RSP_DATA_W-1:0]   rsp_ff;

   logic [MARCH_W-1:0]      step_eff;
   logic signed [MUL_A_W-1:0] mul_a, move_amt;
   logic signed [TRIG_W-1:0]  mul_bx, mul_by;
   logic signed [COORD_W-1:0] cand_x, cand_y, chk_x, chk_y, corr;
   logic                    hit;
   logic                    div_start, div_done;
   logic [DIV_N_W-1:0]      div_dividend, quotient;
   logic [DIV_D_W-1:0]      div_divisor;
   logic [DIV_N_W-1:0]      half_h;
   logic signed [DIV_N_W+1:0] span_lo, span_hi;
   logic [SPAN_W-1:0]       span_start, span_end;
   logic [MAXD_W-1:0]       dist_sat;
   logic [REL_PROD_W-1:0]   rel_prod;
   logic [ANGLE_W-1:0]      rel;

   function automatic logic cell_blocked(input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y,
                                         input logic [WALL_W-1:0] map);
      logic [COORD_W-FRAC_BITS-2:0] cx;
      logic [COORD_W-FRAC_BITS-2:0] cy;
      logic [CELL_W-1:0]            bit_idx;
      logic [WALL_W-1:0]            shifted;
      cx = x[COORD_W-2:FRAC_BITS];
      cy = y[COORD_W-2:FRAC_BITS];
      bit_idx = CELL_W'(cy * MAP_COLUMNS + cx);
      shifted = map >> bit_idx;
      if (x[COORD_W-1] || y[COORD_W-1]) begin
         return 1'b1;
      end
      if (cx >= MAP_COLUMNS || cy >= MAP_ROWS) begin
         return 1'b1;
      end
      if (bit_idx >= WALL_W) begin
         return 1'b1;
      end
      return shifted[0];
   endfunction

   assign step_eff = (cfg.march_step == '0) ? MARCH_W'(1) : cfg.march_step;
   assign move_amt = $signed(MUL_A_W'(cfg.move_step));

   always_comb begin
      case (cmd.mul_sel)
         MUL_MARCH: begin
            mul_a  = $signed({1'b0, dist_ff});
            mul_bx = sine_lookup(ray_ff + ANGLE_W'(QUARTER));
            mul_by = sine_lookup(ray_ff);
         end
         MUL_WALK: begin
            mul_a  = cmd.walk_dir_back ? -move_amt : move_amt;
            mul_bx = sine_lookup(heading_ff + ANGLE_W'(QUARTER));
            mul_by = sine_lookup(heading_ff);
         end
         MUL_CORR: begin
            mul_a  = $signed({1'b0, dist_ff});
            mul_bx = sine_lookup(diff_ff + ANGLE_W'(QUARTER));
            mul_by = '0;
         end
         default: begin
            mul_a  = '0;
            mul_bx = '0;
            mul_by = '0;
         end
      endcase
   end

   assign cand_x = $signed(COORD_W'(pos_x_ff)) + round_q14(prod_x_ff);
   assign cand_y = $signed(COORD_W'(pos_y_ff)) + round_q14(prod_y_ff);
   assign corr   = round_q14(prod_x_ff);

   always_comb begin
      chk_x = cand_x;
      chk_y = cand_y;
      if (cmd.walk_x_upd) begin
         chk_y = $signed(COORD_W'(pos_y_ff));
      end
      if (cmd.walk_y_upd) begin
         chk_x = $signed(COORD_W'(pos_x_ff));
      end
   end

   assign hit = cell_blocked(chk_x, chk_y, cfg.wall_map);

   assign div_start    = cmd.div_start;
   assign div_dividend = DIV_N_W'(SCREEN_HEIGHT * 4096);
   assign div_divisor  = (corr < COORD_W'(1)) ? DIV_D_W'(1) : corr[DIV_D_W-1:0];

   grmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rel_prod = REL_PROD_W'(col_ff) * REL_PROD_W'(REL_MUL);
   assign rel      = rel_prod[REL_PROD_W-1:REL_SHIFT];
   assign ray_in   = heading_ff - ANGLE_W'(HALF_FOV) + rel;
   assign diff_in  = rel - ANGLE_W'(HALF_FOV);

   always_comb begin
      dist_in = dist_ff;
      if (cmd.angle_load) begin
         dist_in = (cfg.max_distance == '0) ? '0 : DIST_W'(step_eff);
      end else if (cmd.dist_step) begin
         dist_in = dist_ff + DIST_W'(step_eff);
      end
   end

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      heading_in = heading_ff;
      if (cmd.walk_x_upd && !hit) begin
         pos_x_in = cand_x[POS_W-1:0];
      end
      if (cmd.walk_y_upd && !hit) begin
         pos_y_in = cand_y[POS_W-1:0];
      end
      if (cmd.turn) begin
         heading_in = heading_ff + (right_ff ? ANGLE_W'(cfg.turn_step) : '0)
                                 - (left_ff ? ANGLE_W'(cfg.turn_step) : '0);
      end
   end

   assign half_h  = quotient >> 1;
   assign span_lo = $signed((DIV_N_W+2)'(SCREEN_HEIGHT / 2)) - $signed({2'b00, half_h});
   assign span_hi = $signed((DIV_N_W+2)'(SCREEN_HEIGHT / 2)) + $signed({2'b00, half_h});
   assign span_start = span_lo[DIV_N_W+1] ? '0 : span_lo[SPAN_W-1:0];
   assign span_end   = (span_hi >= $signed((DIV_N_W+2)'(SCREEN_HEIGHT)))
                       ? SPAN_W'(SCREEN_HEIGHT - 1) : span_hi[SPAN_W-1:0];
   assign dist_sat   = (dist_ff > DIST_W'(DIST_SAT)) ? MAXD_W'(DIST_SAT)
                                                     : dist_ff[MAXD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= POS_RESET;
         pos_y_ff   <= POS_RESET;
         heading_ff <= '0;
      end else begin
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         heading_ff <= heading_in;
      end
      if (cmd.load_item) begin
         back_ff  <= req_tdata[1];
         left_ff  <= req_tdata[2];
         right_ff <= req_tdata[3];
         col_ff   <= req_tdata[13:4];
      end
      if (cmd.angle_load) begin
         ray_ff  <= ray_in;
         diff_ff <= diff_in;
      end
      dist_ff <= dist_in;
      if (cmd.mul_load) begin
         prod_x_ff <= mul_a * mul_bx;
         prod_y_ff <= mul_a * mul_by;
      end
      if (cmd.out_load) begin
         if (cmd.out_cast) begin
            rsp_ff <= {4'b0000, heading_ff, pos_y_ff[POSY_OUT_W-1:0], pos_x_ff,
                       dist_sat, span_end, span_start, col_ff};
         end else begin
            rsp_ff <= {4'b0000, heading_ff, pos_y_ff[POSY_OUT_W-1:0], pos_x_ff,
                       (MAXD_W + 2 * SPAN_W + COL_W)'(0)};
         end
      end
   end

   assign rsp_tdata = rsp_ff;

   assign status.in_op       = req_tuser;
   assign status.in_fwd      = req_tdata[0];
   assign status.in_back     = req_tdata[1];
   assign status.key_back    = back_ff;
   assign status.div_done    = div_done;
   assign status.hit         = hit;
   assign status.dist_lt_max = dist_ff < DIST_W'(cfg.max_distance);
   assign status.max_zero    = cfg.max_distance == '0;

endmodule
`default_nettype wire

// ===== sv/grmc_ctrl.sv =====
`default_nettype none
module grmc_ctrl
   import grmc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b000000000001,
      ST_ANGLE      = 12'b000000000010,
      ST_MARCH_MUL  = 12'b000000000100,
      ST_MARCH_CHK  = 12'b000000001000,
      ST_CORR_MUL   = 12'b000000010000,
      ST_SPAN_START = 12'b000000100000,
      ST_SPAN_WAIT  = 12'b000001000000,
      ST_WALK_MUL   = 12'b000010000000,
      ST_WALK_X     = 12'b000100000000,
      ST_WALK_Y     = 12'b001000000000,
      ST_TURN       = 12'b010000000000,
      ST_DONE       = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      back_ff, back_in;
   logic      cast_ff, cast_in;
   logic      valid_ff, valid_in;

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      back_in  = back_ff;
      cast_in  = cast_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd      = '0;
      cmd.mul_sel       = MUL_MARCH;
      cmd.walk_dir_back = back_ff;
      cmd.out_cast      = cast_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               cast_in       = status.in_op;
               if (status.in_op) begin
                  state_in = ST_ANGLE;
               end else if (status.in_fwd) begin
                  back_in  = 1'b0;
                  state_in = ST_WALK_MUL;
               end else if (status.in_back) begin
                  back_in  = 1'b1;
                  state_in = ST_WALK_MUL;
               end else begin
                  state_in = ST_TURN;
               end
            end
         end
         ST_ANGLE: begin
            cmd.angle_load = 1'b1;
            state_in = status.max_zero ? ST_CORR_MUL : ST_MARCH_MUL;
         end
         ST_MARCH_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_MARCH_CHK;
         end
         ST_MARCH_CHK: begin
            if (status.hit || !status.dist_lt_max) begin
               state_in = ST_CORR_MUL;
            end else begin
               cmd.dist_step = 1'b1;
               state_in      = ST_MARCH_MUL;
            end
         end
         ST_CORR_MUL: begin
            cmd.mul_sel  = MUL_CORR;
            cmd.mul_load = 1'b1;
            state_in     = ST_SPAN_START;
         end
         ST_SPAN_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_SPAN_WAIT;
         end
         ST_SPAN_WAIT: begin
            if (status.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_WALK_MUL: begin
            cmd.mul_sel  = MUL_WALK;
            cmd.mul_load = 1'b1;
            state_in     = ST_WALK_X;
         end
         ST_WALK_X: begin
            cmd.walk_x_upd = 1'b1;
            state_in       = ST_WALK_Y;
         end
         ST_WALK_Y: begin
            cmd.walk_y_upd = 1'b1;
            if (!back_ff && status.key_back) begin
               back_in  = 1'b1;
               state_in = ST_WALK_MUL;
            end else begin
               state_in = ST_TURN;
            end
         end
         ST_TURN: begin
            cmd.turn = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         back_ff  <= 1'b0;
         cast_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         back_ff  <= back_in;
         cast_ff  <= cast_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire
